@@ rtl/core/wts_pkg.sv @@
`default_nettype none

package wts_pkg;

  // default arithmetic widths, signed fixed point
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // item kinds carried on tuser of the input stream
  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_PROJECT = 1'b1
  } mode_e;

  // camera word addresses
  localparam logic [3:0] CAM_RIGHT  = 4'd0;
  localparam logic [3:0] CAM_UP     = 4'd3;
  localparam logic [3:0] CAM_FWD    = 4'd6;
  localparam logic [3:0] CAM_TRANS  = 4'd9;
  localparam logic [3:0] CAM_VIEW   = 4'd12;
  localparam logic [3:0] CAM_DIV    = 4'd14;

  localparam int unsigned CAM_DEPTH = 16;
  localparam int unsigned CAM_AW    = 4;

endpackage

`default_nettype wire

@@ rtl/core/world_to_screen_projection.sv @@
`default_nettype none

// channel   dir  tdata (low bit up)                               tuser
// s_axis    in   coef_index, coef_value, point_x, point_y, point_z  mode
// m_axis    out  screen_x, screen_y                                 visible
//
// a load transaction writes one camera word
// a project transaction runs 3 subtracts, 9 multiply-accumulate pairs and a
// near-plane test, then per axis two divisions on the radix-2 divider plus a
// scale multiply; a point nearer than the near plane skips the divisions and
// leaves with zero screen fields; all divisions run on the single divider
// the input is not ready while a point is in work or its result is unread
// reset clears the camera table to zero and returns the sequencer to idle

module world_to_screen_projection import wts_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned IN_DW  = ((4 + 4 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  // coef_index, coef_value, point_x, point_y, point_z, zero pad
  input  wire  [IN_DW-1:0]  s_axis_tdata,
  // mode
  input  wire               s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  // screen_x, screen_y, zero pad
  output logic [OUT_DW-1:0] m_axis_tdata,
  // visible
  output logic              m_axis_tuser
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = 2 * VALUE_WIDTH + 2;
  localparam int unsigned PW = 2 * VALUE_WIDTH;
  localparam logic signed [AW-1:0] AMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] AMIN = ~AMAX;
  localparam logic [63:0] NEAR_L = ((64'd65 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic signed [W-1:0] NEAR_Q = NEAR_L[W-1:0];
  localparam logic signed [AW-1:0] ONE_A = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB,
    S_MUL,
    S_ACC,
    S_NEAR,
    S_DA_GO,
    S_DA_WT,
    S_DB_GO,
    S_DB_WT,
    S_SMUL,
    S_SACC,
    S_OUT
  } state_e;

  function automatic logic [W-1:0] sat_w(input logic signed [AW-1:0] v);
    logic [W-1:0] r;
    if (v > AMAX) begin
      r = AMAX[W-1:0];
    end else if (v < AMIN) begin
      r = AMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  state_e             state_q;
  logic [W-1:0]       cam_q [CAM_DEPTH];
  logic [W-1:0]       pt_q  [3];
  logic [W-1:0]       d_q   [3];
  logic [W-1:0]       res_q [3];
  logic [W-1:0]       scr_q [2];
  logic [W-1:0]       q1_q;
  logic [W-1:0]       s_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [1:0]         k_q;
  logic [1:0]         r_q;
  logic               a_q;
  logic               vis_q;

  logic [CAM_AW-1:0]  cam_addr;
  logic [W-1:0]       cam_rd;
  logic signed [W:0]  diff;
  logic signed [PW-1:0] prod_sh;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] acc_nx;
  logic signed [AW-1:0] quot_ext;
  logic signed [AW-1:0] scale_sum;
  logic [CAM_AW-1:0]  row_base;

  logic               div_start;
  logic [W-1:0]       div_num;
  logic [W-1:0]       div_den;
  logic               div_busy;
  logic               div_done;
  logic [W-1:0]       div_quot;

  // camera word address for the current step
  always_comb begin
    row_base = {1'b0, r_q, 1'b0} + {2'b00, r_q};
    case (state_q)
      S_SUB:   cam_addr = CAM_TRANS + {2'b00, k_q};
      S_MUL:   cam_addr = row_base + {2'b00, k_q};
      S_DA_GO: cam_addr = CAM_DIV + {3'b000, a_q};
      S_SMUL:  cam_addr = CAM_VIEW + {3'b000, a_q};
      default: cam_addr = CAM_RIGHT;
    endcase
    cam_rd = cam_q[cam_addr];
  end

  // datapath helpers
  always_comb begin
    diff      = $signed({pt_q[k_q][W-1], pt_q[k_q]}) -
                $signed({cam_rd[W-1], cam_rd});
    prod_sh   = prod_q >>> FRAC_BITS;
    prod_ext  = {{(AW-PW){prod_sh[PW-1]}}, prod_sh};
    acc_nx    = acc_q + prod_ext;
    quot_ext  = {{(AW-W){div_quot[W-1]}}, div_quot};
    scale_sum = a_q ? (ONE_A - quot_ext) : (ONE_A + quot_ext);
  end

  // divider operands
  always_comb begin
    div_start = (state_q == S_DA_GO) || (state_q == S_DB_GO);
    div_num   = (state_q == S_DA_GO) ? res_q[{1'b0, a_q}] : q1_q;
    div_den   = (state_q == S_DA_GO) ? cam_rd : res_q[2];
  end

  wts_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // camera table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAM_DEPTH; i++) begin
        cam_q[i] <= '0;
      end
    end else if (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_LOAD)) begin
      cam_q[s_axis_tdata[3:0]] <= s_axis_tdata[4 +: W];
    end
  end

  // sequencer and shared multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      r_q     <= '0;
      a_q     <= 1'b0;
      vis_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && (s_axis_tuser == MODE_PROJECT)) begin
            pt_q[0] <= s_axis_tdata[4 + W +: W];
            pt_q[1] <= s_axis_tdata[4 + 2 * W +: W];
            pt_q[2] <= s_axis_tdata[4 + 3 * W +: W];
            k_q     <= '0;
            r_q     <= '0;
            a_q     <= 1'b0;
            acc_q   <= '0;
            state_q <= S_SUB;
          end
        end
        S_SUB: begin
          d_q[k_q] <= (diff[W] != diff[W-1]) ?
                      (diff[W] ? AMIN[W-1:0] : AMAX[W-1:0]) : diff[W-1:0];
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= S_MUL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_MUL: begin
          prod_q  <= $signed(d_q[k_q]) * $signed(cam_rd);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (k_q == 2'd2) begin
            res_q[r_q] <= sat_w(acc_nx);
            acc_q      <= '0;
            k_q        <= '0;
            if (r_q == 2'd2) begin
              state_q <= S_NEAR;
            end else begin
              r_q     <= r_q + 1'b1;
              state_q <= S_MUL;
            end
          end else begin
            acc_q   <= acc_nx;
            k_q     <= k_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_NEAR: begin
          if ($signed(res_q[2]) < NEAR_Q) begin
            vis_q    <= 1'b0;
            scr_q[0] <= '0;
            scr_q[1] <= '0;
            state_q  <= S_OUT;
          end else begin
            vis_q   <= 1'b1;
            state_q <= S_DA_GO;
          end
        end
        S_DA_GO: begin
          state_q <= S_DA_WT;
        end
        S_DA_WT: begin
          if (div_done) begin
            q1_q    <= div_quot;
            state_q <= S_DB_GO;
          end
        end
        S_DB_GO: begin
          state_q <= S_DB_WT;
        end
        S_DB_WT: begin
          if (div_done) begin
            s_q     <= sat_w(scale_sum);
            state_q <= S_SMUL;
          end
        end
        S_SMUL: begin
          prod_q  <= $signed(cam_rd) * $signed(s_q);
          state_q <= S_SACC;
        end
        S_SACC: begin
          scr_q[a_q] <= sat_w(prod_ext);
          if (a_q) begin
            state_q <= S_OUT;
          end else begin
            a_q     <= 1'b1;
            state_q <= S_DA_GO;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // stream ports
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_OUT;
  assign m_axis_tuser  = vis_q;
  assign m_axis_tdata  = OUT_DW'({scr_q[1], scr_q[0]});

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("hidden point with nonzero screen fields");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not idle after result transaction");

endmodule

`default_nettype wire

@@ rtl/core/wts_div.sv @@
`default_nettype none

// signed fixed-point divider, (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated; restoring radix-2, one quotient bit per cycle
module wts_div import wts_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire signed [VALUE_WIDTH-1:0] num_i,
  input  wire signed [VALUE_WIDTH-1:0] den_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [VALUE_WIDTH-1:0] quot_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned QW = VALUE_WIDTH + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_e;

  dstate_e        state_q;
  logic [CW-1:0]  cnt_q;
  logic [W-1:0]   rem_q;
  logic [W-1:0]   den_q;
  logic [QW-1:0]  qr_q;
  logic           neg_q;
  logic           done_q;
  logic [W-1:0]   quot_q;

  logic [W-1:0]   num_mag;
  logic [W-1:0]   den_mag;
  logic [W:0]     rem_sh;
  logic           ge;
  logic [W:0]     rem_sub;
  logic           big_pos;
  logic           big_neg;
  logic [W-1:0]   q_low;

  // magnitudes of the operands
  always_comb begin
    num_mag = num_i[W-1] ? (~num_i + 1'b1) : num_i;
    den_mag = den_i[W-1] ? (~den_i + 1'b1) : den_i;
  end

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, qr_q[QW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // saturation of the unsigned quotient
  always_comb begin
    q_low   = qr_q[W-1:0];
    big_pos = |qr_q[QW-1:W-1];
    big_neg = big_pos && !((qr_q[QW-1:W] == '0) && (qr_q[W-2:0] == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            if (den_i == '0) begin
              // zero divisor saturates by the sign of the numerator; a zero numerator gives zero
              if (num_i == '0) begin
                quot_q <= '0;
              end else if (num_i[W-1]) begin
                quot_q <= SMIN;
              end else begin
                quot_q <= SMAX;
              end
              done_q <= 1'b1;
            end else begin
              rem_q   <= '0;
              den_q   <= den_mag;
              qr_q    <= {num_mag, {FRAC_BITS{1'b0}}};
              neg_q   <= num_i[W-1] ^ den_i[W-1];
              cnt_q   <= '0;
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
          qr_q  <= {qr_q[QW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(QW - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg_q) begin
            quot_q <= big_neg ? SMIN : (~q_low + 1'b1);
          end else begin
            quot_q <= big_pos ? SMAX : q_low;
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign busy_o = state_q != D_IDLE;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire
